// File: rtl/lpfp_pkg.sv
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types, constants and helpers for the pose frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

   localparam int MAX_CHANNEL_BYTES = 8;

   // header byte counter saturates at the minimum packet size
   localparam logic [3:0] MIN_PACKET     = 4'd10;
   localparam logic [3:0] MAGIC_BYTES    = 4'd4;
   localparam logic [3:0] HEADER_LAST    = 4'd7;
   localparam logic [3:0] CHAN_IDX_MAX   = 4'(MAX_CHANNEL_BYTES + 1);
   localparam logic [3:0] CHAN_LEN_MAX   = 4'(MAX_CHANNEL_BYTES);

   localparam int         POSE_WORDS     = 15;
   localparam logic [6:0] FP_BYTES       = 7'd8;
   localparam logic [6:0] POSE_END       = 7'(8 + 4 * POSE_WORDS);
   localparam logic [6:0] PAYLOAD_SIZE   = 7'd76;
   localparam logic [6:0] PAY_COUNT_MAX  = 7'd77;
   localparam logic [3:0] STAMP_INDEX    = 4'(POSE_WORDS);

   localparam int         CSR_ADDR_W     = 4;
   localparam int         CSR_DATA_W     = 64;
   // register select is address bit 3 (8-byte register spacing)
   localparam logic       REG_CHANNEL_NAME   = 1'b0;
   localparam logic       REG_CHANNEL_LENGTH = 1'b1;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_CHANNEL,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_MAGIC    = 3'd1,
      ST_NO_TERM  = 3'd2,
      ST_CHANNEL  = 3'd3,
      ST_PAYLOAD  = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] sequence_res;
      logic [3:0]  field_index;
      logic [63:0] field_value;
      logic        last;
   } rsp_type;

   // one finished packet, handed from parser to emitter
   typedef struct packed {
      status_type  status;
      logic [31:0] seq;
      logic [63:0] stamp;
   } desc_type;

   typedef struct packed {
      logic        en;
      logic        bank;
      logic [3:0]  index;
      logic [31:0] data;
   } pose_wr_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic wptr;
      logic rptr;
   } q_status_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd0: b = 8'h4C;  // 'L'
         2'd1: b = 8'h43;  // 'C'
         2'd2: b = 8'h30;  // '0'
         2'd3: b = 8'h32;  // '2'
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/lpfp_front.sv
// ----------------------------------------------------------------------------
// lpfp_front
// Byte parser: checks header and channel, collects payload words, and pushes
// a packet descriptor at end of packet.
// ----------------------------------------------------------------------------
module lpfp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lpfp_pkg::req_type     req_data,
   input  lpfp_pkg::q_status_type q_stat,
   input  logic [63:0]           channel_name,
   input  logic [3:0]            channel_length,
   output logic                  push,
   output lpfp_pkg::desc_type    desc,
   output lpfp_pkg::pose_wr_type pose_wr
);

   lpfp_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  hc_ff, hc_in;
   logic        magic_ff, magic_in;
   logic [31:0] seq_ff, seq_in;
   logic [3:0]  ci_ff, ci_in;
   logic        cgood_ff, cgood_in;
   logic [6:0]  pc_ff, pc_in;
   logic [63:0] wa_ff, wa_in;

   logic                 accept;
   logic [7:0]           b;
   logic [3:0]           elen;
   logic [7:0]           name_byte;
   logic [6:0]           pose_off;
   lpfp_pkg::status_type st;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;
   assign b         = req_data.data_byte;
   assign elen      = (channel_length > lpfp_pkg::CHAN_LEN_MAX) ?
                      lpfp_pkg::CHAN_LEN_MAX : channel_length;
   assign name_byte = channel_name[{ci_ff[2:0], 3'b000} +: 8];
   assign pose_off  = pc_ff - lpfp_pkg::FP_BYTES;

   always_comb begin
      phase_in = phase_ff;
      hc_in    = hc_ff;
      magic_in = magic_ff;
      seq_in   = seq_ff;
      ci_in    = ci_ff;
      cgood_in = cgood_ff;
      pc_in    = pc_ff;
      wa_in    = wa_ff;
      st       = lpfp_pkg::ST_OK;
      push     = 1'b0;
      desc     = '0;
      pose_wr.en    = 1'b0;
      pose_wr.bank  = q_stat.wptr;
      pose_wr.index = pose_off[5:2];
      pose_wr.data  = {wa_ff[23:0], b};

      if (accept) begin
         if (hc_ff < lpfp_pkg::MIN_PACKET) begin
            hc_in = hc_ff + 4'd1;
         end
         unique case (phase_ff)
            lpfp_pkg::PH_HEADER: begin
               if (hc_ff < lpfp_pkg::MAGIC_BYTES) begin
                  if (b != lpfp_pkg::magic_byte(hc_ff[1:0])) begin
                     magic_in = 1'b0;
                  end
               end else begin
                  seq_in = {seq_ff[23:0], b};
               end
               if (hc_ff >= lpfp_pkg::HEADER_LAST) begin
                  phase_in = lpfp_pkg::PH_CHANNEL;
               end
            end
            lpfp_pkg::PH_CHANNEL: begin
               if (b == 8'd0) begin
                  if (ci_ff != elen) begin
                     cgood_in = 1'b0;
                  end
                  phase_in = lpfp_pkg::PH_PAYLOAD;
               end else begin
                  // ci_ff >= elen covers every index past the name register
                  if (ci_ff >= elen || b != name_byte) begin
                     cgood_in = 1'b0;
                  end
                  if (ci_ff < lpfp_pkg::CHAN_IDX_MAX) begin
                     ci_in = ci_ff + 4'd1;
                  end
               end
            end
            lpfp_pkg::PH_PAYLOAD: begin
               wa_in = {wa_ff[55:0], b};
               if (pc_ff >= lpfp_pkg::FP_BYTES && pc_ff < lpfp_pkg::POSE_END &&
                   pc_ff[1:0] == 2'd3) begin
                  pose_wr.en = 1'b1;
               end
               if (pc_ff < lpfp_pkg::PAY_COUNT_MAX) begin
                  pc_in = pc_ff + 7'd1;
               end
            end
            default: begin
               phase_in = lpfp_pkg::PH_HEADER;
            end
         endcase

         if (req_data.end_of_packet) begin
            priority if (hc_in < lpfp_pkg::MIN_PACKET || !magic_in) begin
               st = lpfp_pkg::ST_MAGIC;
            end else if (phase_in != lpfp_pkg::PH_PAYLOAD) begin
               st = lpfp_pkg::ST_NO_TERM;
            end else if (elen != 4'd0 && !cgood_in) begin
               st = lpfp_pkg::ST_CHANNEL;
            end else if (pc_in != lpfp_pkg::PAYLOAD_SIZE) begin
               st = lpfp_pkg::ST_PAYLOAD;
            end else begin
               st = lpfp_pkg::ST_OK;
            end
            push        = 1'b1;
            desc.status = st;
            desc.seq    = (st == lpfp_pkg::ST_MAGIC) ? 32'd0 : seq_in;
            // on a good packet the shift register holds the last 8 payload bytes
            desc.stamp  = wa_in;

            phase_in = lpfp_pkg::PH_HEADER;
            hc_in    = 4'd0;
            magic_in = 1'b1;
            seq_in   = 32'd0;
            ci_in    = 4'd0;
            cgood_in = 1'b1;
            pc_in    = 7'd0;
            wa_in    = 64'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lpfp_pkg::PH_HEADER;
         hc_ff    <= 4'd0;
         magic_ff <= 1'b1;
         seq_ff   <= 32'd0;
         ci_ff    <= 4'd0;
         cgood_ff <= 1'b1;
         pc_ff    <= 7'd0;
         wa_ff    <= 64'd0;
      end else begin
         phase_ff <= phase_in;
         hc_ff    <= hc_in;
         magic_ff <= magic_in;
         seq_ff   <= seq_in;
         ci_ff    <= ci_in;
         cgood_ff <= cgood_in;
         pc_ff    <= pc_in;
         wa_ff    <= wa_in;
      end
   end

endmodule

// File: rtl/lpfp_queue.sv
// ----------------------------------------------------------------------------
// lpfp_queue
// Two-entry descriptor queue; slot number doubles as pose bank number.
// ----------------------------------------------------------------------------
module lpfp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lpfp_pkg::desc_type     push_desc,
   input  logic                   pop,
   output lpfp_pkg::desc_type     head,
   output lpfp_pkg::q_status_type q_stat
);

   lpfp_pkg::desc_type slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   assign head         = slot_ff[rptr_ff];
   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);
   assign q_stat.wptr  = wptr_ff;
   assign q_stat.rptr  = rptr_ff;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/lpfp_emit.sv
// ----------------------------------------------------------------------------
// lpfp_emit
// Result sequencer: holds the two pose banks and walks the head packet out
// as sixteen field beats or one error beat, through an output register.
// ----------------------------------------------------------------------------
module lpfp_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  lpfp_pkg::pose_wr_type  pose_wr,
   input  lpfp_pkg::desc_type     head,
   input  lpfp_pkg::q_status_type q_stat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lpfp_pkg::rsp_type      rsp_data
);

   logic [31:0] pose_mem [2][lpfp_pkg::POSE_WORDS];

   logic              rsp_valid_ff, rsp_valid_in;
   lpfp_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [3:0]        idx_ff, idx_in;

   logic        advance;
   logic        fire;
   logic        is_err;
   logic        is_last;
   logic [3:0]  rd_index;
   logic [31:0] word;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (pose_wr.en) begin
         pose_mem[pose_wr.bank][pose_wr.index] <= pose_wr.data;
      end
   end

   assign rd_index = (idx_ff == lpfp_pkg::STAMP_INDEX) ? 4'd0 : idx_ff;
   assign word     = pose_mem[q_stat.rptr][rd_index];

   always_comb begin
      advance = !rsp_valid_ff || !rsp_stall;
      fire    = advance && !q_stat.empty;
      is_err  = (head.status != lpfp_pkg::ST_OK);
      is_last = is_err || (idx_ff == lpfp_pkg::STAMP_INDEX);
      pop     = fire && is_last;

      rsp_data_in.status       = head.status;
      rsp_data_in.sequence_res = head.seq;
      rsp_data_in.field_index  = is_err ? 4'd0 : idx_ff;
      priority if (is_err) begin
         rsp_data_in.field_value = 64'd0;
      end else if (idx_ff == lpfp_pkg::STAMP_INDEX) begin
         rsp_data_in.field_value = head.stamp;
      end else begin
         rsp_data_in.field_value = {32'd0, word};
      end
      rsp_data_in.last = is_last;

      priority if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      priority if (pop) begin
         idx_in = 4'd0;
      end else if (fire) begin
         idx_in = idx_ff + 4'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 4'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

endmodule

// File: rtl/lcm_pose_frame_parser_core.sv
// ----------------------------------------------------------------------------
// lcm_pose_frame_parser_core
// Parser for short "LC02" packets carrying one pose message.
// ----------------------------------------------------------------------------
// Packet bytes are taken one per cycle; the parser never stalls inside a
// packet except when two finished packets are still waiting to be sent. A
// good packet yields sixteen result beats (fifteen pose words, then the
// timestamp) at one beat per unstalled cycle from an output register; a bad
// packet yields one error beat. Finished packets wait in a two-entry queue,
// each entry with its own bank of pose words, so the next packet is parsed
// while the previous one drains; req_stall rises only when both entries are
// full. Program channel_name (offset 0x0) and channel_length (offset 0x8)
// while the block is idle; a length of zero accepts any channel name.
// ----------------------------------------------------------------------------
module lcm_pose_frame_parser_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lpfp_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lpfp_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lpfp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lpfp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lpfp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   logic [63:0] channel_name_ff, channel_name_in;
   logic [3:0]  channel_length_ff, channel_length_in;
   logic        csr_wr;

   lpfp_pkg::q_status_type q_stat;
   lpfp_pkg::desc_type     push_desc;
   lpfp_pkg::desc_type     head;
   lpfp_pkg::pose_wr_type  pose_wr;
   logic                   push;
   logic                   pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      channel_name_in   = channel_name_ff;
      channel_length_in = channel_length_ff;
      csr_prdata        = '0;
      // low address bits are ignored; only bit 3 selects a register
      unique case (csr_paddr[3])
         lpfp_pkg::REG_CHANNEL_NAME: begin
            csr_prdata = channel_name_ff;
            if (csr_wr) begin
               channel_name_in = csr_pwdata;
            end
         end
         lpfp_pkg::REG_CHANNEL_LENGTH: begin
            csr_prdata = {60'd0, channel_length_ff};
            if (csr_wr) begin
               channel_length_in = csr_pwdata[3:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_name_ff   <= 64'd0;
         channel_length_ff <= 4'd0;
      end else begin
         channel_name_ff   <= channel_name_in;
         channel_length_ff <= channel_length_in;
      end
   end

   lpfp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .q_stat         (q_stat),
      .channel_name   (channel_name_ff),
      .channel_length (channel_length_ff),
      .push           (push),
      .desc           (push_desc),
      .pose_wr        (pose_wr)
   );

   lpfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   lpfp_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .pose_wr   (pose_wr),
      .head      (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/lpfp_checker.sv
// ----------------------------------------------------------------------------
// lpfp_checker
// Port-level checks for the pose frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module lpfp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input lpfp_pkg::req_type                 req_data,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input lpfp_pkg::rsp_type                 rsp_data,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic [lpfp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input logic [lpfp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input logic [lpfp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input logic                              csr_pready
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // an error packet is a single beat
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != lpfp_pkg::ST_OK |->
         rsp_data.last && rsp_data.field_index == 4'd0 && rsp_data.field_value == 64'd0)
      else $error("error beat malformed");

   // good packets end exactly at the timestamp beat
   a_ok_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == lpfp_pkg::ST_OK |->
         rsp_data.last == (rsp_data.field_index == lpfp_pkg::STAMP_INDEX))
      else $error("last flag misplaced");

   // pose words occupy only the low half
   a_pose_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == lpfp_pkg::ST_OK &&
         rsp_data.field_index != lpfp_pkg::STAMP_INDEX |->
         rsp_data.field_value[63:32] == 32'd0)
      else $error("pose word has upper bits set");

   // queue is empty after reset, so input is open
   a_reset_open: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind lcm_pose_frame_parser_core lpfp_checker u_lpfp_checker (.*);
